FILE: rtl/sorted_table_binary_search_core_assert.svh
// assertion macros for the sorted table search core checker
// depends on nothing; included by the checker file only
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define STBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/stbs_pkg.sv
// shared types and constants for the sorted table search core
// used by the other rtl files of the block except stbs_fifo; depends on nothing
`timescale 1ns / 1ps

package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 10;
	localparam int OP_W        = 2;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_APPEND,
		CMD_SEARCH,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             rejected;
	} res_t;

endpackage

FILE: rtl/stbs_fifo.sv
// two-entry queue with full/empty flags, used between stages
// depends on nothing
`timescale 1ns / 1ps

module stbs_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= din;
	end

endmodule

FILE: rtl/stbs_front.sv
// front end: takes items, classifies the operation code, queues commands
// depends on stbs_pkg and stbs_fifo
`timescale 1ns / 1ps

module stbs_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [stbs_pkg::OP_W-1:0]             operation,
	input  logic signed [stbs_pkg::VALUE_W-1:0]   value,
	input  logic                                  cmd_pop,
	output logic                                  cmd_valid,
	output stbs_pkg::cmd_t                        cmd
);

	stbs_pkg::cmd_t cmd_in;
	logic           cmd_empty;

	always_comb begin
		cmd_in.value = value;
		unique case (operation)
			stbs_pkg::OP_CLEAR:  cmd_in.kind = stbs_pkg::CMD_CLEAR;
			stbs_pkg::OP_APPEND: cmd_in.kind = stbs_pkg::CMD_APPEND;
			stbs_pkg::OP_SEARCH: cmd_in.kind = stbs_pkg::CMD_SEARCH;
			default:             cmd_in.kind = stbs_pkg::CMD_NOP;
		endcase
	end

	stbs_fifo #(
		.WIDTH($bits(stbs_pkg::cmd_t))
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (cmd),
		.empty (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

FILE: rtl/stbs_back.sv
// back end: entry memory, fill count, binary search sequencer, result queue
// depends on stbs_pkg and stbs_fifo
`timescale 1ns / 1ps

module stbs_back #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  stbs_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic           res_pop,
	output logic           res_empty,
	output stbs_pkg::res_t res
);

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int EXT_W  = ADDR_W + stbs_pkg::POS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP
	} state_t;

	state_t                              state_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic [ADDR_W-1:0]                   lo_q;
	logic [ADDR_W-1:0]                   hi_q;
	logic [ADDR_W-1:0]                   mid_q;
	logic signed [stbs_pkg::VALUE_W-1:0] key_q;
	logic signed [stbs_pkg::VALUE_W-1:0] rd_data_q;
	logic signed [stbs_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];

	logic [ADDR_W:0]   mid_sum;
	logic [ADDR_W-1:0] mid;
	logic              tbl_full;
	logic              start;
	logic              wr_en;
	logic              res_push;
	logic              res_full;
	logic              key_eq;
	logic              key_gt;
	stbs_pkg::res_t    res_d;

	function automatic logic [stbs_pkg::POS_W-1:0] to_pos(input logic [ADDR_W-1:0] a);
		logic [EXT_W-1:0] e;
		e = EXT_W'(a);
		return e[stbs_pkg::POS_W-1:0];
	endfunction

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[ADDR_W:1];
	assign tbl_full = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign start    = (state_q == ST_IDLE) && cmd_valid && !res_full;
	assign key_eq   = (rd_data_q == key_q);
	// entry above the key: search continues in the lower half
	assign key_gt   = (rd_data_q > key_q);

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		wr_en    = 1'b0;
		res_d    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_pop = 1'b1;
					unique case (cmd.kind)
						stbs_pkg::CMD_APPEND: begin
							res_push = 1'b1;
							if (tbl_full) begin
								res_d.rejected = 1'b1;
							end else begin
								wr_en          = 1'b1;
								res_d.position = to_pos(cnt_q[ADDR_W-1:0]);
							end
						end
						stbs_pkg::CMD_SEARCH: begin
							res_push = (cnt_q == '0);
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			ST_CMP: begin
				priority if (key_eq) begin
					res_push       = 1'b1;
					res_d.found    = 1'b1;
					res_d.position = to_pos(mid_q);
				end else if (!key_gt && mid_q == hi_q) begin
					res_push = 1'b1;
				end else if (key_gt && mid_q == lo_q) begin
					res_push = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			key_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (cmd.kind)
							stbs_pkg::CMD_CLEAR: begin
								cnt_q <= '0;
							end
							stbs_pkg::CMD_APPEND: begin
								if (!tbl_full)
									cnt_q <= cnt_q + 1'b1;
							end
							stbs_pkg::CMD_SEARCH: begin
								if (cnt_q != '0) begin
									lo_q    <= '0;
									hi_q    <= ADDR_W'(cnt_q - 1'b1);
									key_q   <= cmd.value;
									state_q <= ST_PROBE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_PROBE: begin
					mid_q   <= mid;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (res_push) begin
						state_q <= ST_IDLE;
					end else begin
						if (key_gt)
							hi_q <= mid_q - 1'b1;
						else
							lo_q <= mid_q + 1'b1;
						state_q <= ST_PROBE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[cnt_q[ADDR_W-1:0]] <= cmd.value;
		if (state_q == ST_PROBE)
			rd_data_q <= mem[mid];
	end

	// room is checked before a command starts, so a push never finds the queue full
	stbs_fifo #(
		.WIDTH($bits(stbs_pkg::res_t))
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_d),
		.full  (res_full),
		.pop   (res_pop),
		.dout  (res),
		.empty (res_empty)
	);

endmodule

FILE: rtl/sorted_table_binary_search_core.sv
// channel   handshake          fields
// input     push / full        operation[1:0], value[31:0] signed
// result    empty / pop        found, position[9:0], rejected
//
// clear, append and unused codes push their result in the back end in the dispatch cycle.
// search on an empty table answers at dispatch, else each probe reads memory and then
// compares, for up to ceil(log2(fill+1)) probes.
// reset clears the fill count and both queues; entry memory is not cleared.
// each side stalls on its own through a two-entry queue at either end.
// top level of the sorted table search core; depends on stbs_pkg, stbs_front, stbs_back
`timescale 1ns / 1ps

module sorted_table_binary_search_core #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [stbs_pkg::OP_W-1:0]           operation,
	input  logic signed [stbs_pkg::VALUE_W-1:0] value,
	output logic                                empty,
	input  logic                                pop,
	output logic                                found,
	output logic [stbs_pkg::POS_W-1:0]          position,
	output logic                                rejected
);

	logic           cmd_valid;
	logic           cmd_pop;
	stbs_pkg::cmd_t cmd;
	stbs_pkg::res_t res;

	stbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.operation(operation),
		.value    (value),
		.cmd_pop  (cmd_pop),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	stbs_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_pop  (pop),
		.res_empty(empty),
		.res      (res)
	);

	assign found    = res.found;
	assign position = res.position;
	assign rejected = res.rejected;

endmodule

FILE: rtl/stbs_checker.sv
// port-level checker for the sorted table search core, bound to the top level
// depends on stbs_pkg and sorted_table_binary_search_core_assert.svh
`timescale 1ns / 1ps
`include "sorted_table_binary_search_core_assert.svh"

module stbs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       push,
	input logic                       full,
	input logic                       empty,
	input logic                       pop,
	input logic                       found,
	input logic [stbs_pkg::POS_W-1:0] position,
	input logic                       rejected
);

	// items taken but whose results are not yet popped
	logic [2:0] outstanding_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= 3'd0;
		end else if (in_acc && !out_acc) begin
			outstanding_q <= outstanding_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			outstanding_q <= outstanding_q - 3'd1;
		end
	end

	`STBS_ASSERT_IMPLY(a_flags_exclusive, clk, arst_n, !empty, !(found && rejected), "found and rejected together")
	`STBS_ASSERT_IMPLY(a_reject_clean, clk, arst_n, !empty && rejected, !found && position == '0, "rejected item carries data")
	`STBS_ASSERT_NEXT(a_result_hold, clk, arst_n, !empty && !pop, !empty && $stable(found) && $stable(position) && $stable(rejected), "waiting result changed")
	`STBS_ASSERT_IMPLY(a_no_phantom, clk, arst_n, !empty || full, outstanding_q != 3'd0, "result or full without an item")

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.push    (push),
	.full    (full),
	.empty   (empty),
	.pop     (pop),
	.found   (found),
	.position(position),
	.rejected(rejected)
);

FILE: sim/sorted_table_binary_search_core_tb.sv
// self-checking testbench for sorted_table_binary_search_core: directed table, full-table fill,
// then random clear / append / search episodes checked against a behavioral table model
// depends on stbs_pkg and the core rtl
`timescale 1ns / 1ps

module sorted_table_binary_search_core_tb;

	localparam logic [stbs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic signed [stbs_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [stbs_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam int RANDOM_ITEMS = 700;

	typedef struct {
		logic [stbs_pkg::OP_W-1:0]           op;
		logic signed [stbs_pkg::VALUE_W-1:0] val;
		bit                                  typed;
		stbs_pkg::res_t                      want;
	} dir_row_t;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                push      = 1'b0;
	logic                                pop       = 1'b0;
	logic [stbs_pkg::OP_W-1:0]           operation = stbs_pkg::OP_CLEAR;
	logic signed [stbs_pkg::VALUE_W-1:0] value     = '0;
	logic                                full;
	logic                                empty;
	logic                                found;
	logic [stbs_pkg::POS_W-1:0]          position;
	logic                                rejected;

	// shadow of the table as the core should hold it
	logic signed [stbs_pkg::VALUE_W-1:0] stored_entries [0:stbs_pkg::TABLE_DEPTH-1];
	int                                  stored_count = 0;

	stbs_pkg::res_t answer_q [$];
	dir_row_t       dir_rows [$];
	int             items_sent      = 0;
	int             results_checked = 0;
	int             hits_seen       = 0;
	int             rejects_seen    = 0;
	int             errors          = 0;
	int             burst_left      = 0;

	sorted_table_binary_search_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.found     (found),
		.position  (position),
		.rejected  (rejected)
	);

	always #10 clk = ~clk;

	function automatic stbs_pkg::res_t mk_res(input logic f,
		input logic [stbs_pkg::POS_W-1:0] p, input logic r);
		stbs_pkg::res_t res;
		res.found    = f;
		res.position = p;
		res.rejected = r;
		return res;
	endfunction

	// applies one item to the shadow table and returns the answer it should give
	function automatic stbs_pkg::res_t table_answer(input logic [stbs_pkg::OP_W-1:0] op,
		input logic signed [stbs_pkg::VALUE_W-1:0] key);
		stbs_pkg::res_t res;
		int             lo;
		int             hi;
		int             mid;
		res = '0;
		case (op)
			stbs_pkg::OP_CLEAR: begin
				stored_count = 0;
			end
			stbs_pkg::OP_APPEND: begin
				if (stored_count >= stbs_pkg::TABLE_DEPTH) begin
					res.rejected = 1'b1;
				end else begin
					stored_entries[stored_count] = key;
					res.position = stored_count[stbs_pkg::POS_W-1:0];
					stored_count++;
				end
			end
			stbs_pkg::OP_SEARCH: begin
				lo = 0;
				hi = stored_count - 1;
				while (lo <= hi && !res.found) begin
					mid = (lo + hi) / 2;
					if (stored_entries[mid] == key) begin
						res.found    = 1'b1;
						res.position = mid[stbs_pkg::POS_W-1:0];
					end else if (stored_entries[mid] < key) begin
						lo = mid + 1;
					end else begin
						hi = mid - 1;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// hands one item to the core; called and returns at a rising edge, after the item is taken
	task automatic send_item(input logic [stbs_pkg::OP_W-1:0] op,
		input logic signed [stbs_pkg::VALUE_W-1:0] val,
		input bit typed = 1'b0, input stbs_pkg::res_t typed_res = '0);
		stbs_pkg::res_t pred;
		push      <= 1'b1;
		operation <= op;
		value     <= val;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pred = table_answer(op, val);
		answer_q.push_back(typed ? typed_res : pred);
		items_sent++;
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 30);
		end else begin
			burst_left--;
		end
	endtask

	// ascending appends; step 0 gives duplicates
	task automatic append_run(input int n, input longint start, input int max_step);
		longint cur;
		cur = start;
		for (int i = 0; i < n; i++) begin
			if (cur > longint'(VAL_MAX))
				cur = longint'(VAL_MAX);
			send_item(stbs_pkg::OP_APPEND, cur[stbs_pkg::VALUE_W-1:0]);
			cur += $urandom_range(0, max_step);
		end
	endtask

	task automatic add_row(input logic [stbs_pkg::OP_W-1:0] op,
		input logic signed [stbs_pkg::VALUE_W-1:0] val,
		input bit typed, input stbs_pkg::res_t want);
		dir_row_t row;
		row.op    = op;
		row.val   = val;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endtask

	// search keys: half stored entries, else neighbors, extremes or random; also unused codes
	task automatic search_some(input int k);
		int                                  pick;
		int                                  idx;
		logic signed [stbs_pkg::VALUE_W-1:0] key;
		for (int i = 0; i < k; i++) begin
			pick = $urandom_range(0, 99);
			idx  = (stored_count > 0) ? $urandom_range(0, stored_count - 1) : 0;
			if (pick < 50 && stored_count > 0) begin
				key = stored_entries[idx];
			end else if (pick < 70 && stored_count > 0) begin
				key = $urandom_range(0, 1) ? stored_entries[idx] + 1
					: stored_entries[idx] - 1;
			end else if (pick < 80) begin
				key = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
			end else if (pick < 88) begin
				send_item(OP_UNUSED, $urandom());
				key = $urandom();
			end else begin
				key = $urandom();
			end
			send_item(stbs_pkg::OP_SEARCH, key);
		end
	endtask

	// receiver: checks each popped item, then picks the next pop level
	logic [12:0] stall_pat = 13'b1011001110101;
	int          pop_mode  = 0;
	int          mode_cnt  = 0;

	always @(posedge clk) begin : result_check
		stbs_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			if (answer_q.size() == 0) begin
				$error("result with nothing expected: found=%0d position=%0d rejected=%0d",
					found, position, rejected);
				errors++;
			end else begin
				want = answer_q.pop_front();
				results_checked++;
				if (found)
					hits_seen++;
				if (rejected)
					rejects_seen++;
				if (found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, found);
					errors++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, actual %0d", want.position, position);
					errors++;
				end
				if (rejected !== want.rejected) begin
					$error("rejected: expected %0d, actual %0d", want.rejected, rejected);
					errors++;
				end
			end
		end
		stall_pat <= {stall_pat[0], stall_pat[12:1]};
		mode_cnt++;
		if (mode_cnt >= 257) begin
			mode_cnt = 0;
			pop_mode = $urandom_range(0, 2);
		end
		case (pop_mode)
			0:       pop <= arst_n;
			1:       pop <= stall_pat[0];
			default: pop <= stall_pat[0] & stall_pat[3];
		endcase
	end

	initial begin : stimulus
		int     base;
		int     n;
		longint start;
		int     max_step;

		add_row(stbs_pkg::OP_SEARCH, 32'sd0, 1'b1, mk_res(1'b0, 10'd0, 1'b0));
		add_row(stbs_pkg::OP_APPEND, VAL_MIN, 1'b1, mk_res(1'b0, 10'd0, 1'b0));
		add_row(stbs_pkg::OP_APPEND, -32'sd1, 1'b1, mk_res(1'b0, 10'd1, 1'b0));
		add_row(stbs_pkg::OP_APPEND, 32'sd0, 1'b1, mk_res(1'b0, 10'd2, 1'b0));
		add_row(stbs_pkg::OP_APPEND, 32'sd1, 1'b1, mk_res(1'b0, 10'd3, 1'b0));
		add_row(stbs_pkg::OP_APPEND, VAL_MAX, 1'b1, mk_res(1'b0, 10'd4, 1'b0));
		add_row(stbs_pkg::OP_SEARCH, VAL_MIN, 1'b0, '0);
		add_row(stbs_pkg::OP_SEARCH, -32'sd1, 1'b0, '0);
		add_row(stbs_pkg::OP_SEARCH, 32'sd0, 1'b0, '0);
		add_row(stbs_pkg::OP_SEARCH, 32'sd1, 1'b0, '0);
		add_row(stbs_pkg::OP_SEARCH, VAL_MAX, 1'b0, '0);
		add_row(stbs_pkg::OP_SEARCH, VAL_MIN + 1, 1'b0, '0);
		add_row(stbs_pkg::OP_SEARCH, VAL_MAX - 1, 1'b0, '0);
		add_row(OP_UNUSED, -32'sd1, 1'b1, mk_res(1'b0, 10'd0, 1'b0));
		add_row(stbs_pkg::OP_SEARCH, 32'sd0, 1'b0, '0);
		// clear keeps the old entries in memory but they no longer count
		add_row(stbs_pkg::OP_CLEAR, VAL_MAX, 1'b1, mk_res(1'b0, 10'd0, 1'b0));
		add_row(stbs_pkg::OP_SEARCH, VAL_MIN, 1'b1, mk_res(1'b0, 10'd0, 1'b0));
		// unsorted table: a present value can be missed
		add_row(stbs_pkg::OP_APPEND, 32'sd9, 1'b1, mk_res(1'b0, 10'd0, 1'b0));
		add_row(stbs_pkg::OP_APPEND, 32'sd3, 1'b1, mk_res(1'b0, 10'd1, 1'b0));
		add_row(stbs_pkg::OP_APPEND, 32'sd5, 1'b1, mk_res(1'b0, 10'd2, 1'b0));
		add_row(stbs_pkg::OP_SEARCH, 32'sd9, 1'b0, '0);
		add_row(stbs_pkg::OP_SEARCH, 32'sd3, 1'b0, '0);
		add_row(stbs_pkg::OP_SEARCH, 32'sd5, 1'b0, '0);
		add_row(stbs_pkg::OP_CLEAR, 32'sd0, 1'b1, mk_res(1'b0, 10'd0, 1'b0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);

		// fill to the last index, then appends on a full table
		append_run(stbs_pkg::TABLE_DEPTH - 1, longint'(VAL_MIN), 4_000_000);
		send_item(stbs_pkg::OP_APPEND, VAL_MAX);
		repeat (3) send_item(stbs_pkg::OP_APPEND, $urandom());
		send_item(stbs_pkg::OP_SEARCH, VAL_MIN);
		send_item(stbs_pkg::OP_SEARCH, VAL_MAX);
		search_some(40);
		send_item(stbs_pkg::OP_CLEAR, $urandom());

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) != 0)
				send_item(stbs_pkg::OP_CLEAR, $urandom());
			n        = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200)
				: $urandom_range(0, 24);
			start    = longint'($signed($urandom()));
			case ($urandom_range(0, 3))
				0:       max_step = 1;
				1:       max_step = 16;
				2:       max_step = 100_000;
				default: max_step = 50_000_000;
			endcase
			append_run(n, start, max_step);
			if ($urandom_range(0, 7) == 0) begin
				send_item(stbs_pkg::OP_APPEND, $urandom());
				append_run($urandom_range(0, 10), start, max_step);
			end
			search_some($urandom_range(4, 20));
		end

		push <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d items (%0d random); checked %0d results",
			items_sent, items_sent - base, results_checked);
		$display("saw %0d search hits and %0d full-table rejects", hits_seen, rejects_seen);
		if (errors == 0 && answer_q.size() == 0) begin
			$display("sorted_table_binary_search_core: match");
		end else begin
			$display("sorted_table_binary_search_core: mismatch");
		end
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("timeout with %0d results outstanding", answer_q.size());
		$display("sorted_table_binary_search_core: mismatch");
		$finish;
	end

endmodule
